[hw/rtl/assert_macros.svh]
// Assertion helpers; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AM_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");
`define AM_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define AM_ALWAYS(lbl, clk, rstn, prop)
`define AM_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hw/rtl/csma_pkg.sv]
package csma_pkg;

  localparam int SUM_W  = 64;
  localparam int ROOT_W = 33;
  localparam int OUT_W  = 48;
  localparam int CFG_W  = 4;

  localparam logic [CFG_W-1:0] NUM_CH_RESET = 4'd8;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_READ = 1'b1;

  localparam logic [3:0] MS_NONE = 4'd0;
  localparam logic [3:0] MS_AC   = 4'd1;
  localparam logic [3:0] MS_BD   = 4'd2;
  localparam logic [3:0] MS_BC   = 4'd3;
  localparam logic [3:0] MS_AD   = 4'd4;
  localparam logic [3:0] MS_IM   = 4'd5;
  localparam logic [3:0] MS_RR   = 4'd6;
  localparam logic [3:0] MS_II   = 4'd7;
  localparam logic [3:0] MS_SUM  = 4'd8;

  typedef struct packed {
    logic       in_latch;
    logic       buf_we;
    logic       clr_we;
    logic       buf_rd;
    logic       buf_sel_col;
    logic       lat_row;
    logic       lat_col;
    logic [3:0] mstep;
    logic       acc_rd;
    logic       rd_sel;
    logic       sq_start;
    logic       acc_wr;
    logic       pair_init;
    logic       pair_inc;
    logic       out_load;
  } csma_cmd_t;

  typedef struct packed {
    logic is_read;
    logic pass_trig;
    logic clr_last;
    logic last_pair;
    logic sq_done;
  } csma_status_t;

endpackage

[hw/rtl/cross_spectral_magnitude_accumulator.sv]
// Load item: written to the channel buffer on acceptance; a load of the last
// channel in use starts a pair pass of n*n pairs (buffer reads, one shared
// multiplier, a 32-step square root, read-modify-write of the accumulator
// memory). Read item: the entry is read, then loaded into the output register
// once it is free. Reset: synchronous; the accumulator memory is cleared one
// entry a cycle, all BINS*CHANNELS*CHANNELS, before any item is accepted.
module cross_spectral_magnitude_accumulator #(
  parameter int CHANNELS     = 8,
  parameter int BINS         = 1024,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [csma_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_action,
  input  logic [9:0]                     in_bin,
  input  logic [2:0]                     in_channel,
  input  logic [2:0]                     in_partner_channel,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_imag,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csma_pkg::OUT_W-1:0]     out_acc_value,
  output logic                           out_saturated
);
  import csma_pkg::*;
  `include "assert_macros.svh"

  csma_cmd_t    cmd;
  csma_status_t status;

  csma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  csma_datapath #(
    .CHANNELS     (CHANNELS),
    .BINS         (BINS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ACC_WIDTH    (ACC_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .status             (status),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .in_action          (in_action),
    .in_bin             (in_bin),
    .in_channel         (in_channel),
    .in_partner_channel (in_partner_channel),
    .in_sample_real     (in_sample_real),
    .in_sample_imag     (in_sample_imag),
    .out_acc_value      (out_acc_value),
    .out_saturated      (out_saturated)
  );

  `AM_ALWAYS(a_no_accept_in_clear, clk, rst_n, !(cmd.clr_we && in_ready))
  `AM_ALWAYS(a_one_writer, clk, rst_n, !(cmd.clr_we && cmd.acc_wr))
  `AM_NEXT(a_sqrt_restart, clk, rst_n, cmd.sq_start, !status.sq_done)
  `AM_NEXT(a_load_holds_out, clk, rst_n, cmd.out_load, out_valid)
endmodule

[hw/rtl/csma_sqrt.sv]
module csma_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [csma_pkg::SUM_W-1:0]  radicand,
  output logic                        done,
  output logic [csma_pkg::ROOT_W-1:0] root
);
  import csma_pkg::*;

  logic [SUM_W-1:0] n_r, n_nxt, r_r, r_nxt, bit_r, bit_nxt, t;
  logic             done_r, done_nxt;

  always_comb begin
    t        = r_r + bit_r;
    n_nxt    = n_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    done_nxt = done_r;
    if (start) begin
      n_nxt    = radicand;
      r_nxt    = '0;
      bit_nxt  = SUM_W'(1) << (SUM_W - 2);
      done_nxt = 1'b0;
    end else if (bit_r != '0) begin
      if (n_r >= t) begin
        n_nxt = n_r - t;
        r_nxt = (r_r >> 1) + bit_r;
      end else begin
        r_nxt = r_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == SUM_W'(1)) done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bit_r  <= '0;
      done_r <= 1'b0;
    end else begin
      bit_r  <= bit_nxt;
      done_r <= done_nxt;
    end
    n_r <= n_nxt;
    r_r <= r_nxt;
  end

  assign done = done_r;
  assign root = ROOT_W'(r_r) + ROOT_W'(n_r > r_r);
endmodule

[hw/rtl/csma_datapath.sv]
module csma_datapath #(
  parameter int CHANNELS     = 8,
  parameter int BINS         = 1024,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH    = 48
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  csma_pkg::csma_cmd_t              cmd,
  output csma_pkg::csma_status_t           status,
  input  logic                             cfg_we,
  input  logic [csma_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                             in_action,
  input  logic [9:0]                       in_bin,
  input  logic [2:0]                       in_channel,
  input  logic [2:0]                       in_partner_channel,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_real,
  input  logic signed [SAMPLE_WIDTH-1:0]   in_sample_imag,
  output logic [csma_pkg::OUT_W-1:0]       out_acc_value,
  output logic                             out_saturated
);
  import csma_pkg::*;

  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH2     = CHANNELS * CHANNELS;
  localparam int ENTRIES = BINS * CH2;
  localparam int AW      = $clog2(ENTRIES);
  localparam int RW      = 2 * SAMPLE_WIDTH + 1;
  localparam int PXW     = (2 * RW > SUM_W) ? 2 * RW : SUM_W;
  localparam int EW      = ACC_WIDTH + 2;
  localparam int NW      = 5;

  logic [CFG_W-1:0] cfg_r;
  logic [NW-1:0]    n_eff;
  logic [9:0]       bin_r;
  logic [2:0]       ch_r, pch_r;
  logic             oor_r;
  logic [CW-1:0]    row_r, col_r, buf_addr;
  logic [AW-1:0]    clr_r, pair_addr, rd_addr, acc_addr, wr_addr;

  logic [2*SAMPLE_WIDTH-1:0] buf_mem [CHANNELS];
  logic [2*SAMPLE_WIDTH-1:0] buf_q_r;
  logic signed [SAMPLE_WIDTH-1:0] a_r, b_r, c_r, d_r;
  logic signed [RW-1:0]  op_a, op_b, re_r, re_nxt, im_r, im_nxt;
  logic signed [PXW-1:0] prod_r, prod_nxt;
  logic [SUM_W-1:0]      s_r, s_nxt;

  logic [ACC_WIDTH:0]   acc_mem [ENTRIES];
  logic [ACC_WIDTH:0]   acc_q_r, wr_data;
  logic [ACC_WIDTH-1:0] cur, mx, headroom;
  logic [ROOT_W-1:0]    root;
  logic                 sq_done;

  always_comb begin
    if (cfg_r == '0) n_eff = NW'(1);
    else if (32'(cfg_r) > CHANNELS) n_eff = NW'(CHANNELS);
    else n_eff = NW'(cfg_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cfg_r <= NUM_CH_RESET;
    else if (cfg_we) cfg_r <= cfg_wdata;
  end

  assign status.is_read   = (in_action == ACT_READ);
  assign status.pass_trig = (in_action == ACT_LOAD) && (32'(in_channel) < CHANNELS) &&
                            (NW'(in_channel) == n_eff - NW'(1)) && (32'(in_bin) < BINS);
  assign status.clr_last  = (32'(clr_r) == ENTRIES - 1);
  assign status.last_pair = (NW'(row_r) == n_eff - NW'(1)) &&
                            (NW'(col_r) == n_eff - NW'(1));
  assign status.sq_done   = sq_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (cmd.clr_we) begin
      clr_r <= clr_r + AW'(1);
    end
    if (cmd.in_latch) begin
      bin_r <= in_bin;
      ch_r  <= in_channel;
      pch_r <= in_partner_channel;
      oor_r <= (32'(in_bin) >= BINS) || (32'(in_channel) >= CHANNELS) ||
               (32'(in_partner_channel) >= CHANNELS);
    end
    if (cmd.pair_init) begin
      row_r <= '0;
      col_r <= '0;
    end else if (cmd.pair_inc) begin
      if (NW'(col_r) == n_eff - NW'(1)) begin
        col_r <= '0;
        row_r <= row_r + CW'(1);
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  assign buf_addr = cmd.buf_sel_col ? col_r : row_r;

  always_ff @(posedge clk) begin
    if (cmd.buf_we && (32'(in_channel) < CHANNELS))
      buf_mem[CW'(in_channel)] <= {in_sample_real, in_sample_imag};
    if (cmd.buf_rd) buf_q_r <= buf_mem[buf_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.lat_row) begin
      a_r <= buf_q_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      b_r <= buf_q_r[SAMPLE_WIDTH-1:0];
    end
    if (cmd.lat_col) begin
      c_r <= buf_q_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      d_r <= buf_q_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    op_a   = RW'(a_r);
    op_b   = RW'(c_r);
    re_nxt = re_r;
    im_nxt = im_r;
    s_nxt  = s_r;
    unique case (cmd.mstep)
      MS_AC: begin
        op_a = RW'(a_r);
        op_b = RW'(c_r);
      end
      MS_BD: begin
        op_a   = RW'(b_r);
        op_b   = RW'(d_r);
        re_nxt = signed'(prod_r[RW-1:0]);
      end
      MS_BC: begin
        op_a   = RW'(b_r);
        op_b   = RW'(c_r);
        re_nxt = re_r - signed'(prod_r[RW-1:0]);
      end
      MS_AD: begin
        op_a   = RW'(a_r);
        op_b   = RW'(d_r);
        im_nxt = signed'(prod_r[RW-1:0]);
      end
      MS_IM: im_nxt = im_r + signed'(prod_r[RW-1:0]);
      MS_RR: begin
        op_a = re_r;
        op_b = re_r;
      end
      MS_II: begin
        op_a  = im_r;
        op_b  = im_r;
        s_nxt = prod_r[SUM_W-1:0];
      end
      MS_SUM: s_nxt = s_r + prod_r[SUM_W-1:0];
      default: ;
    endcase
    prod_nxt = PXW'(op_a * op_b);
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    re_r   <= re_nxt;
    im_r   <= im_nxt;
    s_r    <= s_nxt;
  end

  csma_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.sq_start),
    .radicand (s_r),
    .done     (sq_done),
    .root     (root)
  );

  assign pair_addr = AW'(32'(bin_r) * CH2 + 32'(row_r) * CHANNELS + 32'(col_r));
  assign rd_addr   = AW'(32'(bin_r) * CH2 + 32'(ch_r) * CHANNELS + 32'(pch_r));
  assign acc_addr  = cmd.rd_sel ? rd_addr : pair_addr;
  assign wr_addr   = cmd.clr_we ? clr_r : pair_addr;

  assign cur      = acc_q_r[ACC_WIDTH-1:0];
  assign mx       = '1;
  assign headroom = mx - cur;

  always_comb begin
    if (cmd.clr_we) wr_data = '0;
    else if (EW'(root) >= EW'(headroom)) wr_data = {1'b1, mx};
    else wr_data = {acc_q_r[ACC_WIDTH], ACC_WIDTH'(EW'(cur) + EW'(root))};
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_we || cmd.acc_wr) acc_mem[wr_addr] <= wr_data;
    if (cmd.acc_rd) acc_q_r <= acc_mem[acc_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_acc_value <= oor_r ? '0 : OUT_W'(acc_q_r[ACC_WIDTH-1:0]);
      out_saturated <= oor_r ? 1'b0 : acc_q_r[ACC_WIDTH];
    end
  end
endmodule

[hw/rtl/csma_ctrl.sv]
module csma_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  csma_pkg::csma_status_t status,
  output csma_pkg::csma_cmd_t    cmd
);
  import csma_pkg::*;

  localparam logic [4:0] ST_CLR  = 5'd0;
  localparam logic [4:0] ST_IDLE = 5'd1;
  localparam logic [4:0] ST_RD   = 5'd2;
  localparam logic [4:0] ST_RDW  = 5'd3;
  localparam logic [4:0] ST_RA   = 5'd4;
  localparam logic [4:0] ST_RB   = 5'd5;
  localparam logic [4:0] ST_CD   = 5'd6;
  localparam logic [4:0] ST_AC   = 5'd7;
  localparam logic [4:0] ST_BD   = 5'd8;
  localparam logic [4:0] ST_BC   = 5'd9;
  localparam logic [4:0] ST_AD   = 5'd10;
  localparam logic [4:0] ST_IM   = 5'd11;
  localparam logic [4:0] ST_RR   = 5'd12;
  localparam logic [4:0] ST_II   = 5'd13;
  localparam logic [4:0] ST_SUM  = 5'd14;
  localparam logic [4:0] ST_SQS  = 5'd15;
  localparam logic [4:0] ST_SQ   = 5'd16;
  localparam logic [4:0] ST_ACC  = 5'd17;

  logic [4:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_CLR: begin
        cmd.clr_we = 1'b1;
        if (status.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          cmd.in_latch  = 1'b1;
          cmd.pair_init = 1'b1;
          if (status.is_read) begin
            state_nxt = ST_RD;
          end else begin
            cmd.buf_we = 1'b1;
            if (status.pass_trig) state_nxt = ST_RA;
          end
        end
      end
      ST_RD: begin
        cmd.acc_rd = 1'b1;
        cmd.rd_sel = 1'b1;
        state_nxt  = ST_RDW;
      end
      ST_RDW: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_RA: begin
        cmd.buf_rd = 1'b1;
        state_nxt  = ST_RB;
      end
      ST_RB: begin
        cmd.lat_row     = 1'b1;
        cmd.buf_rd      = 1'b1;
        cmd.buf_sel_col = 1'b1;
        state_nxt       = ST_CD;
      end
      ST_CD: begin
        cmd.lat_col = 1'b1;
        state_nxt   = ST_AC;
      end
      ST_AC:  begin cmd.mstep = MS_AC;  state_nxt = ST_BD;  end
      ST_BD:  begin cmd.mstep = MS_BD;  state_nxt = ST_BC;  end
      ST_BC:  begin cmd.mstep = MS_BC;  state_nxt = ST_AD;  end
      ST_AD:  begin cmd.mstep = MS_AD;  state_nxt = ST_IM;  end
      ST_IM:  begin cmd.mstep = MS_IM;  state_nxt = ST_RR;  end
      ST_RR:  begin cmd.mstep = MS_RR;  state_nxt = ST_II;  end
      ST_II:  begin cmd.mstep = MS_II;  state_nxt = ST_SUM; end
      ST_SUM: begin
        cmd.mstep  = MS_SUM;
        cmd.acc_rd = 1'b1;
        state_nxt  = ST_SQS;
      end
      ST_SQS: begin
        cmd.sq_start = 1'b1;
        state_nxt    = ST_SQ;
      end
      ST_SQ: begin
        if (status.sq_done) state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc_wr   = 1'b1;
        cmd.pair_inc = 1'b1;
        state_nxt    = status.last_pair ? ST_IDLE : ST_RA;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end
endmodule
